// ----- sv/ktb_pkg.sv -----
// Shared constants, types and move tables for the knight's tour search block.
// No dependencies; every other file of the block but ktb_ram imports this package.
package ktb_pkg;

    localparam int MAX_SIDE    = 8;
    localparam int CELLS       = MAX_SIDE * MAX_SIDE;
    localparam int NUM_MOVES   = 8;
    localparam int STACK_DEPTH = CELLS + 1;

    localparam int SIDE_W  = $clog2(MAX_SIDE);
    localparam int NSIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CELL_W  = $clog2(CELLS);
    localparam int DEPTH_W = $clog2(CELLS + 1);
    localparam int COORD_W = SIDE_W + 2;
    localparam int MOVE_W  = 4;
    localparam int STEP_W  = 7;
    localparam int CFG_W   = 4;
    localparam int START_W = 3;
    localparam int MIN_SIDE = 3;

    typedef struct packed {
        logic start;
        logic clear;
        logic place;
        logic probe;
        logic retreat;
        logic back_up;
        logic advance;
        logic set_found;
        logic dump_load;
        logic dump_next;
    } ktb_cmd_t;

    typedef struct packed {
        logic start_ok;
        logic clear_done;
        logic at_total;
        logic move_over;
        logic depth_low;
        logic target_ok;
        logic cell_free;
        logic dump_end;
    } ktb_status_t;

    // Row change of knight move k; moves are numbered 1 to 8.
    function automatic logic signed [COORD_W-1:0] row_delta(input logic [MOVE_W-1:0] k);
        logic signed [COORD_W-1:0] d;
        case (k)
            4'd1: d = COORD_W'(2);
            4'd2: d = COORD_W'(1);
            4'd3: d = COORD_W'(-1);
            4'd4: d = COORD_W'(-2);
            4'd5: d = COORD_W'(-2);
            4'd6: d = COORD_W'(-1);
            4'd7: d = COORD_W'(1);
            4'd8: d = COORD_W'(2);
            default: d = '0;
        endcase
        return d;
    endfunction

    // Column change of knight move k.
    function automatic logic signed [COORD_W-1:0] col_delta(input logic [MOVE_W-1:0] k);
        logic signed [COORD_W-1:0] d;
        case (k)
            4'd1: d = COORD_W'(1);
            4'd2: d = COORD_W'(2);
            4'd3: d = COORD_W'(2);
            4'd4: d = COORD_W'(1);
            4'd5: d = COORD_W'(-1);
            4'd6: d = COORD_W'(-2);
            4'd7: d = COORD_W'(-2);
            4'd8: d = COORD_W'(-1);
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [CELL_W-1:0] cell_index(input logic [SIDE_W-1:0] row,
                                                     input logic [SIDE_W-1:0] col);
        return CELL_W'(int'(row) * MAX_SIDE + int'(col));
    endfunction

endpackage

// ----- sv/knight_tour_backtrack_search.sv -----
// Knight's tour search: one start square in, n*n board squares out.
// Operation: the board is cleared, then moves are tried one at a time (data dependent
// and exponential in the worst case) through the one-read-port move stack and board
// memories; the board is then dumped square by square.
// Throughput: one item at a time; a new item is accepted once the dump's last square is taken.
// Reset (rst_n, asynchronous, active low): idle, side register 8, memories not reset.
module knight_tour_backtrack_search
    import ktb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   board_size,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [START_W-1:0] start_x,
    input  logic [START_W-1:0] start_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STEP_W-1:0]  square_step,
    output logic               found,
    output logic               last
);

    // The controller only issues commands; all state of the search, including
    // the board of step numbers and the per-depth stack of move indices, lives
    // in the datapath. The board is swept to zero at the start of every item,
    // which also covers a start square that lies off the board.
    ktb_cmd_t    cmd;
    ktb_status_t status;

    // The side register may be written at any time; writes are only meaningful
    // while the block is idle.
    assign cfg_ready = 1'b1;

    ktb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    ktb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .board_size  (board_size),
        .start_x     (start_x),
        .start_y     (start_y),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .square_step (square_step),
        .found       (found),
        .last        (last)
    );

    // A result item is never offered while the block is waiting for a new start.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("result offered while idle");

    // Accepting a start square makes the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("still ready after accepting a start square");

    // Taking the final square of the dump returns the block to idle.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("not idle after the last square");

    // Taking any other square keeps the dump going.
    a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> !in_ready)
        else $error("dump ended before the last square");

endmodule

// ----- sv/ktb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the board and the move stack.
module ktb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ktb_datapath.sv -----
// Datapath of the knight's tour search: position, depth, board and move stack
// memories, board clear sweep and dump counters. Depends on ktb_pkg and ktb_ram.
module ktb_datapath
    import ktb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [CFG_W-1:0]   board_size,
    input  logic [START_W-1:0] start_x,
    input  logic [START_W-1:0] start_y,
    input  ktb_cmd_t           cmd,
    output ktb_status_t        status,
    output logic               out_valid,
    output logic [STEP_W-1:0]  square_step,
    output logic               found,
    output logic               last
);

    logic [CFG_W-1:0]   board_size_reg;
    logic [NSIDE_W-1:0] side_reg, side_in;
    logic [DEPTH_W-1:0] total_reg;
    logic [SIDE_W-1:0]  row0_reg, col0_reg;
    logic               start_ok_reg;
    logic [SIDE_W-1:0]  cur_row_reg, cur_row_next;
    logic [SIDE_W-1:0]  cur_col_reg, cur_col_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [SIDE_W-1:0]  u_reg, v_reg;
    logic [CELL_W-1:0]  clr_cnt_reg;
    logic [SIDE_W-1:0]  dump_row_reg, dump_col_reg;
    logic               found_reg, out_valid_reg, last_reg;
    logic [STEP_W-1:0]  square_step_reg;

    logic [MOVE_W-1:0]          ms_rdata, k_try;
    logic [STEP_W-1:0]          board_rdata;
    logic signed [COORD_W-1:0]  u_try, v_try, u_back, v_back;
    logic [SIDE_W-1:0]          side_last;

    logic                ms_we;
    logic [DEPTH_W-1:0]  ms_waddr;
    logic [MOVE_W-1:0]   ms_wdata;
    logic                bd_we;
    logic [CELL_W-1:0]   bd_waddr, bd_raddr;
    logic [STEP_W-1:0]   bd_wdata;

    // Side in use, with out-of-range settings pulled into the legal span.
    always_comb
    begin
        if (32'(board_size_reg) < MIN_SIDE)
        begin
            side_in = NSIDE_W'(MIN_SIDE);
        end
        else if (32'(board_size_reg) > MAX_SIDE)
        begin
            side_in = NSIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_in = NSIDE_W'(board_size_reg);
        end
    end

    assign side_last = SIDE_W'(side_reg - 1'b1);

    // Next move from the current square, and the square it reaches.
    assign k_try = ms_rdata + 1'b1;
    assign u_try = $signed(COORD_W'(cur_row_reg)) + row_delta(k_try);
    assign v_try = $signed(COORD_W'(cur_col_reg)) + col_delta(k_try);
    // Undo the move that led to the current square.
    assign u_back = $signed(COORD_W'(cur_row_reg)) - row_delta(ms_rdata);
    assign v_back = $signed(COORD_W'(cur_col_reg)) - col_delta(ms_rdata);

    assign status.start_ok   = start_ok_reg;
    assign status.clear_done = (clr_cnt_reg == CELL_W'(CELLS - 1));
    assign status.at_total   = (depth_reg >= total_reg);
    assign status.move_over  = (k_try > MOVE_W'(NUM_MOVES));
    assign status.depth_low  = (depth_reg <= DEPTH_W'(1));
    assign status.target_ok  = !u_try[COORD_W-1] && (u_try < $signed(COORD_W'(side_reg)))
                            && !v_try[COORD_W-1] && (v_try < $signed(COORD_W'(side_reg)));
    assign status.cell_free  = (board_rdata == '0);
    assign status.dump_end   = (dump_row_reg == side_last) && (dump_col_reg == side_last);

    always_comb
    begin
        ms_we    = cmd.probe | cmd.place | cmd.advance;
        ms_waddr = depth_reg;
        ms_wdata = '0;
        if (cmd.probe)
        begin
            ms_wdata = k_try;
        end
        else if (cmd.place)
        begin
            ms_waddr = DEPTH_W'(1);
        end
        else if (cmd.advance)
        begin
            ms_waddr = depth_reg + 1'b1;
        end
    end

    always_comb
    begin
        bd_we    = cmd.clear | cmd.place | cmd.retreat | cmd.advance;
        bd_waddr = clr_cnt_reg;
        bd_wdata = '0;
        if (cmd.place)
        begin
            bd_waddr = cell_index(row0_reg, col0_reg);
            bd_wdata = STEP_W'(1);
        end
        else if (cmd.retreat)
        begin
            bd_waddr = cell_index(cur_row_reg, cur_col_reg);
        end
        else if (cmd.advance)
        begin
            bd_waddr = cell_index(u_reg, v_reg);
            bd_wdata = STEP_W'(depth_reg + 1'b1);
        end
    end

    assign bd_raddr = cmd.probe ? cell_index(u_try[SIDE_W-1:0], v_try[SIDE_W-1:0])
                                : cell_index(dump_row_reg, dump_col_reg);

    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        depth_next   = depth_reg;
        if (cmd.place)
        begin
            cur_row_next = row0_reg;
            cur_col_next = col0_reg;
            depth_next   = DEPTH_W'(1);
        end
        else if (cmd.retreat)
        begin
            depth_next = depth_reg - 1'b1;
        end
        else if (cmd.back_up)
        begin
            cur_row_next = SIDE_W'(u_back);
            cur_col_next = SIDE_W'(v_back);
        end
        else if (cmd.advance)
        begin
            cur_row_next = u_reg;
            cur_col_next = v_reg;
            depth_next   = depth_reg + 1'b1;
        end
    end

    ktb_ram #(.WIDTH(MOVE_W), .DEPTH(STACK_DEPTH)) u_move_stack (
        .clk   (clk),
        .we    (ms_we),
        .waddr (ms_waddr),
        .wdata (ms_wdata),
        .raddr (depth_reg),
        .rdata (ms_rdata)
    );

    ktb_ram #(.WIDTH(STEP_W), .DEPTH(CELLS)) u_board (
        .clk   (clk),
        .we    (bd_we),
        .waddr (bd_waddr),
        .wdata (bd_wdata),
        .raddr (bd_raddr),
        .rdata (board_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_size_reg <= CFG_W'(MAX_SIDE);
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            depth_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                board_size_reg <= board_size;
            end
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            depth_reg   <= depth_next;
            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.dump_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.dump_next)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            side_reg     <= side_in;
            total_reg    <= DEPTH_W'(32'(side_in) * 32'(side_in));
            row0_reg     <= SIDE_W'(start_x);
            col0_reg     <= SIDE_W'(start_y);
            start_ok_reg <= (32'(start_x) < 32'(side_in)) && (32'(start_y) < 32'(side_in));
            clr_cnt_reg  <= '0;
            dump_row_reg <= '0;
            dump_col_reg <= '0;
        end
        if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
        if (cmd.probe)
        begin
            u_reg <= SIDE_W'(u_try);
            v_reg <= SIDE_W'(v_try);
        end
        if (cmd.dump_load)
        begin
            square_step_reg <= board_rdata;
            last_reg        <= status.dump_end;
        end
        if (cmd.dump_next)
        begin
            if (dump_col_reg == side_last)
            begin
                dump_col_reg <= '0;
                dump_row_reg <= dump_row_reg + 1'b1;
            end
            else
            begin
                dump_col_reg <= dump_col_reg + 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign square_step = square_step_reg;
    assign found       = found_reg;
    assign last        = last_reg;

endmodule

// ----- sv/ktb_ctrl.sv -----
// Controller state machine of the knight's tour search: sequences clear,
// search steps, backtracking and the board dump. Depends on ktb_pkg.
module ktb_ctrl
    import ktb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        out_ready,
    input  ktb_status_t status,
    output logic        in_ready,
    output ktb_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_CLEAR = 11'b000_0000_0010,
        ST_PLACE = 11'b000_0000_0100,
        ST_CHECK = 11'b000_0000_1000,
        ST_PROBE = 11'b000_0001_0000,
        ST_TEST  = 11'b000_0010_0000,
        ST_BKRD  = 11'b000_0100_0000,
        ST_BKUP  = 11'b000_1000_0000,
        ST_DRD   = 11'b001_0000_0000,
        ST_DLD   = 11'b010_0000_0000,
        ST_DHOLD = 11'b100_0000_0000
    } ktb_state_t;

    ktb_state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = status.start_ok ? ST_PLACE : ST_DRD;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.at_total)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_DRD;
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (status.move_over)
                begin
                    if (status.depth_low)
                    begin
                        state_next = ST_DRD;
                    end
                    else
                    begin
                        cmd.retreat = 1'b1;
                        state_next  = ST_BKRD;
                    end
                end
                else if (status.target_ok)
                begin
                    state_next = ST_TEST;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_TEST:
            begin
                cmd.advance = status.cell_free;
                state_next  = ST_CHECK;
            end
            ST_BKRD:
            begin
                state_next = ST_BKUP;
            end
            ST_BKUP:
            begin
                cmd.back_up = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_DRD:
            begin
                state_next = ST_DLD;
            end
            ST_DLD:
            begin
                cmd.dump_load = 1'b1;
                state_next    = ST_DHOLD;
            end
            ST_DHOLD:
            begin
                if (out_ready)
                begin
                    cmd.dump_next = 1'b1;
                    state_next    = status.dump_end ? ST_IDLE : ST_DRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ----- sim/knight_tour_checker.sv -----
`timescale 1ns / 100ps
// Checker for the knight's tour search block: it watches the three channels,
// predicts each board dump and compares it square by square.
// Depends on ktb_pkg for widths and limits.
module knight_tour_checker
    import ktb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CFG_W-1:0]   board_size,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [START_W-1:0] start_x,
    input  logic [START_W-1:0] start_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [STEP_W-1:0]  square_step,
    input  logic               found,
    input  logic               last,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              found;
        logic              last;
    } square_t;

    square_t           expected_squares [$];
    logic [CFG_W-1:0]  size_copy = 4'd8;
    logic [STEP_W-1:0] board_copy [0:CELLS-1];
    logic [MOVE_W-1:0] move_tried [0:CELLS];
    int                mismatches = 0;
    int                waiting = 0;
    int                square_no = 0;
    square_t           want;

    assign fail_count    = mismatches;
    assign pending_count = waiting;

    function automatic int side_in_force();
        if (size_copy < MIN_SIDE)
            return MIN_SIDE;
        if (size_copy > MAX_SIDE)
            return MAX_SIDE;
        return int'(size_copy);
    endfunction

    function automatic int jump_row(input int k);
        case (k)
            1, 8:    return 2;
            2, 7:    return 1;
            3, 6:    return -1;
            4, 5:    return -2;
            default: return 0;
        endcase
    endfunction

    function automatic int jump_col(input int k);
        case (k)
            1, 4:    return 1;
            2, 3:    return 2;
            5, 8:    return -1;
            6, 7:    return -2;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t mismatch on %s at square %0d: got %0d, expected %0d",
                 $realtime, what, square_no, got, exp_val);
        mismatches++;
    endtask

    // Depth-first search with an explicit stack of the move last tried at
    // each depth, then the whole board queued in row-major order.
    task automatic predict_board(input logic [START_W-1:0] row0,
                                 input logic [START_W-1:0] col0);
        int      n;
        int      total;
        int      depth;
        int      k;
        int      r;
        int      c;
        int      u;
        int      v;
        int      i;
        bit      toured;
        bit      searching;
        square_t sq;
        n      = side_in_force();
        total  = n * n;
        toured = 1'b0;
        for (i = 0; i < CELLS; i++)
            board_copy[i] = '0;
        if (int'(row0) < n && int'(col0) < n) begin
            r = int'(row0);
            c = int'(col0);
            board_copy[r * MAX_SIDE + c] = STEP_W'(1);
            depth         = 1;
            move_tried[1] = '0;
            searching     = 1'b1;
            while (searching) begin
                if (depth >= total) begin
                    toured    = 1'b1;
                    searching = 1'b0;
                end else begin
                    k = int'(move_tried[depth]) + 1;
                    move_tried[depth] = MOVE_W'(k);
                    if (k > NUM_MOVES) begin
                        // All eight moves tried here: step back along the path.
                        if (depth <= 1) begin
                            searching = 1'b0;
                        end else begin
                            board_copy[r * MAX_SIDE + c] = '0;
                            depth--;
                            k = int'(move_tried[depth]);
                            r = r - jump_row(k);
                            c = c - jump_col(k);
                        end
                    end else begin
                        u = r + jump_row(k);
                        v = c + jump_col(k);
                        if (u >= 0 && u < n && v >= 0 && v < n &&
                            board_copy[u * MAX_SIDE + v] == 0) begin
                            depth++;
                            board_copy[u * MAX_SIDE + v] = STEP_W'(depth);
                            r = u;
                            c = v;
                            move_tried[depth] = '0;
                        end
                    end
                end
            end
        end
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
                sq.step  = board_copy[r * MAX_SIDE + c];
                sq.found = toured;
                sq.last  = (r == n - 1) && (c == n - 1);
                expected_squares.push_back(sq);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_copy = 4'd8;
            expected_squares.delete();
            waiting   = 0;
            square_no = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_squares.size() == 0)
                begin
                    report_mismatch("square with no item pending", int'(square_step), 0);
                end
                else
                begin
                    want = expected_squares.pop_front();
                    if (square_step !== want.step)
                        report_mismatch("square_step", int'(square_step), int'(want.step));
                    if (found !== want.found)
                        report_mismatch("found", int'(found), int'(want.found));
                    if (last !== want.last)
                        report_mismatch("last", int'(last), int'(want.last));
                end
                square_no = (last === 1'b1) ? 0 : square_no + 1;
            end
            if (cfg_valid && cfg_ready)
                size_copy = board_size;
            if (in_valid && in_ready)
                predict_board(start_x, start_y);
            waiting = expected_squares.size();
        end
    end

endmodule

// ----- sim/tb_knight_tour_backtrack_search.sv -----
`timescale 1ns / 100ps
// Testbench top for the knight's tour search block: clock, reset, stimulus
// and verdict. Depends on ktb_pkg, the block itself and knight_tour_checker.
module tb_knight_tour_backtrack_search;
    import ktb_pkg::*;

    // A search stalls every channel for its whole length. The slowest search
    // run here is the single five-by-five tour from a corner, so the watchdog
    // allows far more idle cycles than that one search can take.
    localparam int STALL_LIMIT     = 50_000_000;
    // The receiver's one long hold-off, long enough for the block to finish
    // its search and back up into its input.
    localparam int HOLD_CYCLES     = 500;
    // Every item yields at least nine squares, so once the last expected square
    // is out the block is idle again; a few spare cycles are kept anyway.
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 200;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 10;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   board_size;
    logic               in_valid;
    logic               in_ready;
    logic [START_W-1:0] start_x;
    logic [START_W-1:0] start_y;
    logic               out_valid;
    logic               out_ready;
    logic [STEP_W-1:0]  square_step;
    logic               found;
    logic               last;

    int fail_count;
    int pending_count;
    int stall_cycles = 0;

    // Idling controls shared between the sender and the receiver process.
    // An eager side never idles; hold_req asks the receiver for one long stall.
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    bit hold_req = 1'b0;

    always #1 clk = ~clk;

    knight_tour_backtrack_search i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .board_size  (board_size),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_x     (start_x),
        .start_y     (start_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .square_step (square_step),
        .found       (found),
        .last        (last)
    );

    knight_tour_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .board_size    (board_size),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_x       (start_x),
        .start_y       (start_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .square_step   (square_step),
        .found         (found),
        .last          (last),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // The watchdog counts cycles in which no item moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // The receiver draws a random wait before every square, or none at all
    // while eager. A pending hold request replaces that wait with one long
    // stall, counted here, while the sender keeps offering.
    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_eager ? 0 : $urandom_range(0, 7);
            if (hold_req)
            begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            @(negedge clk);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Offers one start square after a random gap. It returns at the rising
    // edge that took the item, so in_valid stays high into the next item when
    // no gap is drawn, and is only lowered by the caller or by the next gap.
    task automatic send_start(input logic [START_W-1:0] row, input logic [START_W-1:0] col);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= row;
        start_y  <= col;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits until every predicted square has come out, then a little longer.
    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes the side register; only called while the block is idle.
    task automatic write_side(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid  <= 1'b1;
        board_size <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int               phase;
        int               item;
        int               side;
        bit               on_board;
        logic [CFG_W-1:0] setting;
        logic [START_W-1:0] row;
        logic [START_W-1:0] col;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        board_size = '0;
        in_valid   = 1'b0;
        start_x    = '0;
        start_y    = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Smallest board. A corner start walks the eight-square ring around
        // the center and fails; the center has no move at all; starts at or
        // beyond the side give an empty board with no search.
        write_side(4'd3);
        send_start(3'd0, 3'd0);
        send_start(3'd1, 3'd1);
        send_start(3'd2, 3'd2);
        send_start(3'd0, 3'd2);
        send_start(3'd2, 3'd0);
        send_start(3'd3, 3'd1);
        send_start(3'd1, 3'd3);
        send_start(3'd7, 3'd7);
        stop_sending();
        drain();

        // A side below three is used as three.
        write_side(4'd0);
        send_start(3'd2, 3'd1);
        send_start(3'd0, 3'd5);
        stop_sending();
        drain();

        // Four by four has no tour, so each on-board start square runs the whole
        // search space before the board comes back with the start alone.
        write_side(4'd4);
        send_start(3'd0, 3'd0);
        send_start(3'd1, 3'd2);
        send_start(3'd3, 3'd3);
        send_start(3'd4, 3'd4);
        stop_sending();
        drain();

        // Five by five is the smallest board with a tour; the corner start
        // finds one. The larger sides only get off-board starts, since a
        // full search there can run for an unbounded number of moves.
        write_side(4'd5);
        send_start(3'd0, 3'd0);
        send_start(3'd5, 3'd2);
        send_start(3'd1, 3'd5);
        stop_sending();
        drain();

        write_side(4'd6);
        send_start(3'd6, 3'd6);
        send_start(3'd0, 3'd7);
        stop_sending();
        drain();

        write_side(4'd7);
        send_start(3'd7, 3'd3);
        stop_sending();
        drain();

        // Sides above the maximum are used as the maximum. On an eight by
        // eight board every start is on the board, so no item is sent here.
        write_side(4'd15);
        write_side(4'd9);

        // Back pressure: the receiver stalls for a long stretch while the
        // sender offers items back to back, so the block fills and holds
        // its input. The sender then pauses until every square is out.
        write_side(4'd3);
        tx_eager = 1'b1;
        hold_req = 1'b1;
        send_start(3'd0, 3'd1);
        send_start(3'd2, 3'd2);
        send_start(3'd1, 3'd0);
        send_start(3'd1, 3'd1);
        stop_sending();
        drain();
        tx_eager = 1'b0;

        // Random phases, each under a random side setting. On the three by
        // three board most starts land on the board; on four by four only a
        // few do, as each one costs a full search; larger sides get
        // off-board starts only.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            setting  = CFG_W'($urandom_range(0, 7));
            side     = (setting < MIN_SIDE) ? MIN_SIDE : int'(setting);
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            write_side(setting);
            for (item = 0; item < ITEMS_PER_PHASE; item++)
            begin
                if (side == 3)
                    on_board = ($urandom_range(0, 9) < 7);
                else if (side == 4)
                    on_board = ($urandom_range(0, 3) == 0);
                else
                    on_board = 1'b0;
                if (on_board)
                begin
                    row = START_W'($urandom_range(0, side - 1));
                    col = START_W'($urandom_range(0, side - 1));
                end
                else if ($urandom_range(0, 1) == 1)
                begin
                    row = START_W'($urandom_range(side, 7));
                    col = START_W'($urandom_range(0, 7));
                end
                else
                begin
                    row = START_W'($urandom_range(0, 7));
                    col = START_W'($urandom_range(side, 7));
                end
                send_start(row, col);
            end
            stop_sending();
            drain();
        end

        // Give any stray square time to show up before the verdict.
        repeat (END_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ktb_pkg.sv
sv/ktb_ram.sv
sv/ktb_datapath.sv
sv/ktb_ctrl.sv
sv/knight_tour_backtrack_search.sv
sim/knight_tour_checker.sv
sim/tb_knight_tour_backtrack_search.sv
